[hw/rtl/stereo_iir_lowpass_output_stage_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stereo IIR lowpass output stage
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_IIR_LOWPASS_OUTPUT_STAGE_ASSERT_SVH
`define STEREO_IIR_LOWPASS_OUTPUT_STAGE_ASSERT_SVH

// Same-cycle implication
`define SILOS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SILOS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/silos_pkg.sv]
// ----------------------------------------------------------------------------
// silos_pkg
// Shared constants, control word types and the microcode table of the
// stereo IIR lowpass output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package silos_pkg;

  // Sizes
  localparam int MAX_SECTIONS = 8;
  localparam int SLOTS        = 4;
  localparam int SLOT_W       = 2;
  localparam int COEF_W       = 13;
  localparam int SAMPLE_W     = 32;
  localparam int OUT_W        = 16;
  localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);
  localparam int COEF_DEPTH   = MAX_SECTIONS * SLOTS;
  localparam int HIST_DEPTH   = 2 * (1 << SEC_W);     // rows addressed by {channel, section}
  localparam int FRAC_W       = 10;                   // coefficients scaled by 1024
  localparam int PROD_W       = SAMPLE_W + COEF_W;
  localparam int ACC_W        = PROD_W + 2;           // three products summed
  localparam int STEP_W       = 4;
  localparam int STEP_LAST    = 8;

  // Input commands
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_COEF  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Register indexes
  localparam logic CFG_FILTER_ENABLE = 1'b0;
  localparam logic CFG_SECTION_COUNT = 1'b1;

  // Coefficient slots
  localparam logic [SLOT_W-1:0] SLOT_C0 = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_C1 = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_C2 = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_C3 = 2'd3;

  typedef enum logic [1:0] {
    MUL_H0 = 2'd0,
    MUL_H1 = 2'd1,
    MUL_P  = 2'd2
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctl_t;

  typedef struct packed {
    logic              hist_rd;
    logic              coef_rd;
    logic [SLOT_W-1:0] coef_slot;
    mul_sel_t          mul_sel;
    mac_ctl_t          mac;
    logic              p_ld;
    logic              y_ld;
    logic              hist_wr;
    logic              br_sec;
  } uword_t;

  // Microprogram for one section of one channel.
  // Coefficient and history reads are registered, and so is a product; each
  // is used in the step after the read or multiply that issued it.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '0;
    w.mul_sel    = MUL_H0;
    w.mac.acc_op = ACC_HOLD;
    case (step)
      4'd0: begin                 // fetch history row and c0
        w.hist_rd   = 1'b1;
        w.coef_rd   = 1'b1;
        w.coef_slot = SLOT_C0;
      end
      4'd1: begin                 // h0*c0, fetch c1
        w.coef_rd    = 1'b1;
        w.coef_slot  = SLOT_C1;
        w.mul_sel    = MUL_H0;
        w.mac.mul_en = 1'b1;
      end
      4'd2: begin                 // h1*c1, acc = h0*c0, fetch c2
        w.coef_rd    = 1'b1;
        w.coef_slot  = SLOT_C2;
        w.mul_sel    = MUL_H1;
        w.mac.mul_en = 1'b1;
        w.mac.acc_op = ACC_LOAD;
      end
      4'd3: begin                 // h1*c2, acc += h1*c1
        w.mul_sel    = MUL_H1;
        w.mac.mul_en = 1'b1;
        w.mac.acc_op = ACC_ADD;
      end
      4'd4: begin                 // p = o + acc/1024, acc = h1*c2
        w.p_ld       = 1'b1;
        w.mac.acc_op = ACC_LOAD;
      end
      4'd5: begin                 // p*c2, fetch c3
        w.coef_rd    = 1'b1;
        w.coef_slot  = SLOT_C3;
        w.mul_sel    = MUL_P;
        w.mac.mul_en = 1'b1;
      end
      4'd6: begin                 // h0*c3, acc += p*c2
        w.mul_sel    = MUL_H0;
        w.mac.mul_en = 1'b1;
        w.mac.acc_op = ACC_ADD;
      end
      4'd7: begin                 // acc += h0*c3
        w.mac.acc_op = ACC_ADD;
      end
      4'd8: begin                 // y = acc/1024, update history, branch
        w.y_ld    = 1'b1;
        w.hist_wr = 1'b1;
        w.br_sec  = 1'b1;
      end
      default: begin
        w.br_sec = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Shift right by 8 and clamp to 16 bits
  function automatic logic [OUT_W-1:0] cut8(input logic signed [SAMPLE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] s;
    s = v >>> 8;
    if (s > 32'sd32767) begin
      return 16'h7fff;
    end else if (s < -32'sd32768) begin
      return 16'h8000;
    end
    return s[OUT_W-1:0];
  endfunction

  // Saturate above 0x7fff*8 and below -0x8000*8, then shift right by 3
  function automatic logic [OUT_W-1:0] cut3(input logic signed [SAMPLE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] s;
    s = v >>> 3;
    if (v > 32'sd262136) begin
      return 16'h7fff;
    end else if (v < -32'sd262144) begin
      return 16'h8000;
    end
    return s[OUT_W-1:0];
  endfunction

endpackage

[hw/rtl/silos_mac.sv]
// ----------------------------------------------------------------------------
// silos_mac
// Shared 32x13 signed multiplier with product register, accumulator and
// divide-by-1024 rounding toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module silos_mac (
  input  logic                                     clk,
  input  silos_pkg::mac_ctl_t                      ctl,
  input  logic signed [silos_pkg::SAMPLE_W-1:0]    mul_a,
  input  logic signed [silos_pkg::COEF_W-1:0]      mul_b,
  output logic        [silos_pkg::SAMPLE_W-1:0]    quo
);

  logic signed [silos_pkg::PROD_W-1:0] prod_r;
  logic signed [silos_pkg::ACC_W-1:0]  acc_r;
  logic signed [silos_pkg::ACC_W-1:0]  prod_ext;
  logic                                round_up;

  // Product register
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  assign prod_ext = {{(silos_pkg::ACC_W - silos_pkg::PROD_W){prod_r[silos_pkg::PROD_W-1]}},
                     prod_r};

  // Accumulator
  always_ff @(posedge clk) begin
    case (ctl.acc_op)
      silos_pkg::ACC_LOAD: acc_r <= prod_ext;
      silos_pkg::ACC_ADD:  acc_r <= acc_r + prod_ext;
      default:             acc_r <= acc_r;
    endcase
  end

  // Truncating division: negative values with a fraction step up by one
  assign round_up = acc_r[silos_pkg::ACC_W-1] & (|acc_r[silos_pkg::FRAC_W-1:0]);
  assign quo = acc_r[silos_pkg::FRAC_W +: silos_pkg::SAMPLE_W]
             + {{(silos_pkg::SAMPLE_W-1){1'b0}}, round_up};

endmodule

[hw/rtl/stereo_iir_lowpass_output_stage.sv]
// ----------------------------------------------------------------------------
// stereo_iir_lowpass_output_stage
// Turns mixed 32-bit stereo accumulators into 16-bit samples, optionally
// through a cascade of fixed-point biquad lowpass sections.
// ----------------------------------------------------------------------------
// Operation: one beat is taken at a time. With the filter on, a frame runs
// the N active sections (section_count, capped at 8): a microcoded loop of 9
// steps runs each section once per channel on one shared 32x13 multiplier,
// left channel first. With the filter off, or with N of zero, a frame goes
// straight to the output register. Coefficient writes and history clears give
// no result. The output register lets a new beat in while the last result
// waits. History is cleared at once by per-section valid bits, so no clearing
// pass follows reset; coefficients are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stereo_iir_lowpass_output_stage_assert.svh"

module stereo_iir_lowpass_output_stage (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input beats
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_cmd,
  input  logic signed [silos_pkg::SAMPLE_W-1:0]  in_left_sum,
  input  logic signed [silos_pkg::SAMPLE_W-1:0]  in_right_sum,
  input  logic [2:0]                             in_coef_section,
  input  logic [silos_pkg::SLOT_W-1:0]           in_coef_slot,
  input  logic signed [silos_pkg::COEF_W-1:0]    in_coef_value,
  // result beats
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [silos_pkg::OUT_W-1:0]     out_left,
  output logic signed [silos_pkg::OUT_W-1:0]     out_right,
  // register writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_index,
  input  logic [3:0]                             cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam int SEC_W  = silos_pkg::SEC_W;
  localparam int CNT_W  = silos_pkg::CNT_W;
  localparam int STEP_W = silos_pkg::STEP_W;
  localparam int SW     = silos_pkg::SAMPLE_W;

  state_t                          state_r, state_nxt;
  logic [STEP_W-1:0]               step_r, step_nxt;
  logic [SEC_W-1:0]                sec_r, sec_nxt;
  logic                            chan_r, chan_nxt;
  logic                            filter_enable_r;
  logic [3:0]                      section_count_r;
  logic [silos_pkg::MAX_SECTIONS-1:0] hist_valid_r, hist_valid_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [silos_pkg::OUT_W-1:0]     out_left_r, out_right_r;
  logic signed [SW-1:0]            val_l_r, val_r_r, p_r;

  logic [CNT_W-1:0]                n_eff;
  logic                            in_acc, cfg_acc, run, done_load;
  silos_pkg::uword_t               ctl;
  silos_pkg::mac_ctl_t             mac_ctl;
  logic [SW-1:0]                   quo;
  logic signed [SW-1:0]            cur_val, h0_eff, h1_eff, mul_a;

  // Memories
  logic signed [silos_pkg::COEF_W-1:0] coef_mem [silos_pkg::COEF_DEPTH];
  logic signed [silos_pkg::COEF_W-1:0] coef_q_r;
  logic [2*SW-1:0]                     hist_mem [silos_pkg::HIST_DEPTH];
  logic [2*SW-1:0]                     hist_q_r;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;
  assign run       = (state_r == S_RUN);
  assign done_load = (state_r == S_DONE) & (~out_valid_r | out_ready);

  // Active sections, capped
  assign n_eff = (int'(section_count_r) > silos_pkg::MAX_SECTIONS)
               ? CNT_W'(silos_pkg::MAX_SECTIONS) : CNT_W'(section_count_r);

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_enable_r <= 1'b0;
      section_count_r <= 4'd1;
    end else if (cfg_acc) begin
      if (cfg_index == silos_pkg::CFG_FILTER_ENABLE) begin
        filter_enable_r <= cfg_data[0];
      end else begin
        section_count_r <= cfg_data;
      end
    end
  end

  // Microcode fetch, gated outside the run state
  always_comb begin
    ctl     = silos_pkg::ucode(step_r);
    mac_ctl = ctl.mac;
    if (!run) begin
      ctl.hist_rd    = 1'b0;
      ctl.coef_rd    = 1'b0;
      ctl.p_ld       = 1'b0;
      ctl.y_ld       = 1'b0;
      ctl.hist_wr    = 1'b0;
      mac_ctl.mul_en = 1'b0;
      mac_ctl.acc_op = silos_pkg::ACC_HOLD;
    end
  end

  // Coefficient memory
  always_ff @(posedge clk) begin
    if (in_acc && (in_cmd == silos_pkg::CMD_COEF) &&
        (int'(in_coef_section) < silos_pkg::MAX_SECTIONS)) begin
      coef_mem[{SEC_W'(in_coef_section), in_coef_slot}] <= in_coef_value;
    end
    if (ctl.coef_rd) begin
      coef_q_r <= coef_mem[{sec_r, ctl.coef_slot}];
    end
  end

  // History memory: one row per channel and section, {h1, h0}
  assign h0_eff = hist_valid_r[sec_r] ? signed'(hist_q_r[SW-1:0])  : '0;
  assign h1_eff = hist_valid_r[sec_r] ? signed'(hist_q_r[2*SW-1:SW]) : '0;

  always_ff @(posedge clk) begin
    if (ctl.hist_wr) begin
      hist_mem[{chan_r, sec_r}] <= {h0_eff, p_r};
    end
    if (ctl.hist_rd) begin
      hist_q_r <= hist_mem[{chan_r, sec_r}];
    end
  end

  // Multiplier operand select
  always_comb begin
    case (ctl.mul_sel)
      silos_pkg::MUL_H1: mul_a = h1_eff;
      silos_pkg::MUL_P:  mul_a = p_r;
      default:           mul_a = h0_eff;
    endcase
  end

  silos_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .mul_a (mul_a),
    .mul_b (coef_q_r),
    .quo   (quo)
  );

  assign cur_val = chan_r ? val_r_r : val_l_r;

  // Channel values: input sample, then the running section output
  always_ff @(posedge clk) begin
    if (in_acc && (in_cmd == silos_pkg::CMD_FRAME)) begin
      if (filter_enable_r) begin
        val_l_r <= in_left_sum >>> 5;
        val_r_r <= in_right_sum >>> 5;
      end else begin
        val_l_r <= in_left_sum;
        val_r_r <= in_right_sum;
      end
    end else if (ctl.y_ld) begin
      if (chan_r) begin
        val_r_r <= signed'(quo);
      end else begin
        val_l_r <= signed'(quo);
      end
    end
    if (ctl.p_ld) begin
      p_r <= cur_val + signed'(quo);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (done_load) begin
      if (filter_enable_r) begin
        out_left_r  <= silos_pkg::cut3(val_l_r);
        out_right_r <= silos_pkg::cut3(val_r_r);
      end else begin
        out_left_r  <= silos_pkg::cut8(val_l_r);
        out_right_r <= silos_pkg::cut8(val_r_r);
      end
    end
  end

  // Sequencer and control
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    sec_nxt        = sec_r;
    chan_nxt       = chan_r;
    hist_valid_nxt = hist_valid_r;
    out_valid_nxt  = out_valid_r & ~out_ready;

    if (cfg_acc && (cfg_index == silos_pkg::CFG_FILTER_ENABLE) && cfg_data[0]) begin
      hist_valid_nxt = '0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            silos_pkg::CMD_FRAME: begin
              step_nxt = '0;
              sec_nxt  = '0;
              chan_nxt = 1'b0;
              if (filter_enable_r && (n_eff != '0)) begin
                state_nxt = S_RUN;
              end else begin
                state_nxt = S_DONE;
              end
            end
            silos_pkg::CMD_CLEAR: begin
              hist_valid_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_RUN: begin
        if (ctl.hist_wr && chan_r) begin
          hist_valid_nxt[sec_r] = 1'b1;
        end
        if (ctl.br_sec) begin
          step_nxt = '0;
          if (int'(sec_r) + 1 < int'(n_eff)) begin
            sec_nxt = sec_r + 1'b1;
          end else if (!chan_r) begin
            sec_nxt  = '0;
            chan_nxt = 1'b1;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DONE: begin
        if (done_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      sec_r        <= '0;
      chan_r       <= 1'b0;
      hist_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      sec_r        <= sec_nxt;
      chan_r       <= chan_nxt;
      hist_valid_r <= hist_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Checks
  `SILOS_ASSERT_NEXT(a_run_entry,
    in_acc && (in_cmd == silos_pkg::CMD_FRAME) && filter_enable_r && (n_eff != '0),
    (state_r == S_RUN) && (step_r == '0) && (sec_r == '0) && !chan_r,
    "filtered frame did not start at step zero of the left channel")
  `SILOS_ASSERT_SAME(a_sec_in_range, state_r == S_RUN,
    int'(sec_r) < int'(n_eff), "section index beyond active count")
  `SILOS_ASSERT_SAME(a_step_in_range, state_r == S_RUN,
    int'(step_r) <= silos_pkg::STEP_LAST, "microcode step beyond program end")
  `SILOS_ASSERT_NEXT(a_done_holds, (state_r == S_DONE) && out_valid_r && !out_ready,
    state_r == S_DONE, "result overwrote a beat still waiting")
  `SILOS_ASSERT_NEXT(a_clear, in_acc && (in_cmd == silos_pkg::CMD_CLEAR),
    hist_valid_r == '0, "history clear left a section valid")

endmodule
